FILE: hw/rtl/dtpd_pkg.sv
// Shared types and constants of the digit trie prefix detector.
// No dependencies; imported by the top level.
`default_nettype none

package dtpd_pkg;

	// Request command codes
	typedef enum logic {
		CMD_DIGIT = 1'b0,
		CMD_CLEAR = 1'b1
	} cmd_t;

	// Fixed field widths
	localparam int DIGIT_W = 4;
	localparam int OUT_W   = 15;

	// Node id of the root; id zero means "no child"
	localparam int ROOT_NODE = 1;

endpackage

`default_nettype wire

FILE: hw/rtl/dtpd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; holds the child link rows of the trie.
`default_nettype none

module dtpd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/digit_trie_prefix_detector_top.sv
// Clear and digits of a lost walk finish in the idle state; a digit that follows a
// stored link reads the RAM, then resolves; one that allocates a node reads the RAM,
// writes the parent row, then zeroes the new node's row on the single write port.
// Requests are taken only in idle; a final digit holds while the output is full, then
// its result is registered. Reset: asynchronous; init zeroes the root row first.
// Depends on dtpd_pkg and dtpd_ram.
`default_nettype none

module digit_trie_prefix_detector_top
	import dtpd_pkg::*;
#(
	parameter int NODE_COUNT = 16384,
	parameter int RADIX      = 10
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output      logic               in_ready,
	input  wire logic               command,
	input  wire logic [DIGIT_W-1:0] digit,
	input  wire logic               last_digit,
	output      logic               out_valid,
	input  wire logic               out_ready,
	output      logic               already_present,
	output      logic               pool_overflow,
	output      logic [OUT_W-1:0]   nodes_used
);

	localparam int NODE_W = $clog2(NODE_COUNT);
	localparam int CNT_W  = $clog2(NODE_COUNT + 1);
	localparam int DIG_W  = $clog2(RADIX);
	localparam int ROW_W  = RADIX * NODE_W;

	localparam logic [DIGIT_W:0]  RADIX_V = (DIGIT_W + 1)'(RADIX);
	localparam logic [CNT_W-1:0]  FULL_V  = CNT_W'(NODE_COUNT);
	localparam logic [CNT_W-1:0]  FREE_RST = CNT_W'(ROOT_NODE + 1);
	localparam logic [NODE_W-1:0] ROOT_V  = NODE_W'(ROOT_NODE);

	// Sequencer states
	localparam logic [2:0] ST_INIT = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_LOOK = 3'd2;
	localparam logic [2:0] ST_ZERO = 3'd3;
	localparam logic [2:0] ST_HOLD = 3'd4;

	typedef logic [RADIX-1:0][NODE_W-1:0] row_t;

	logic [2:0]        state_q, state_n;
	logic [NODE_W-1:0] cur_q, cur_n;
	logic [CNT_W-1:0]  free_q, free_n;
	logic              lost_q, lost_n;
	logic              missed_q, missed_n;
	logic              ovf_q, ovf_n;
	logic [DIG_W-1:0]  dig_q;
	logic              last_q;

	logic              out_valid_q;
	logic              out_present_q;
	logic              out_ovf_q;
	logic [OUT_W-1:0]  out_used_q;

	logic              mem_we;
	logic [NODE_W-1:0] mem_waddr;
	row_t              mem_wdata;
	logic              mem_re;
	row_t              mem_rdata;
	row_t              row_mod;
	logic [NODE_W-1:0] rd_link;

	logic              accept;
	logic              digit_ok;
	logic              out_free;
	logic              finish;
	logic              fin_last;
	logic              emit;
	logic              res_present;
	logic              res_ovf;
	logic [CNT_W+OUT_W-1:0] used_wide;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign digit_ok = ({1'b0, digit} < RADIX_V);
	assign out_free = !out_valid_q || out_ready;
	assign rd_link  = mem_rdata[dig_q];

	// Child link rows, one row per node
	dtpd_ram #(
		.WIDTH(ROW_W),
		.DEPTH(NODE_COUNT)
	) u_links (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(cur_q),
		.rdata(mem_rdata)
	);

	// Walk sequencer: clear the root, read the row, resolve the link, allocate and zero a fresh row
	always_comb begin
		state_n     = state_q;
		cur_n       = cur_q;
		free_n      = free_q;
		lost_n      = lost_q;
		missed_n    = missed_q;
		ovf_n       = ovf_q;
		mem_we      = 1'b0;
		mem_waddr   = cur_q;
		mem_wdata   = '0;
		mem_re      = 1'b0;
		row_mod     = mem_rdata;
		finish      = 1'b0;
		fin_last    = last_q;
		emit        = 1'b0;
		res_present = 1'b0;
		res_ovf     = 1'b0;
		used_wide   = '0;
		case (state_q)
			ST_INIT: begin
				mem_we    = 1'b1;
				mem_waddr = ROOT_V;
				state_n   = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					if (command == CMD_CLEAR) begin
						mem_we    = 1'b1;
						mem_waddr = ROOT_V;
						free_n    = FREE_RST;
						cur_n     = ROOT_V;
						lost_n    = 1'b0;
						missed_n  = 1'b0;
						ovf_n     = 1'b0;
					end else if (lost_q || !digit_ok) begin
						lost_n   = 1'b1;
						missed_n = 1'b1;
						finish   = 1'b1;
						fin_last = last_digit;
					end else begin
						mem_re  = 1'b1;
						state_n = ST_LOOK;
					end
				end
			end
			ST_LOOK: begin
				if (rd_link != '0) begin
					cur_n  = rd_link;
					finish = 1'b1;
				end else begin
					missed_n = 1'b1;
					if (free_q == FULL_V) begin
						ovf_n  = 1'b1;
						lost_n = 1'b1;
						finish = 1'b1;
					end else begin
						row_mod[dig_q] = free_q[NODE_W-1:0];
						mem_we         = 1'b1;
						mem_wdata      = row_mod;
						cur_n          = free_q[NODE_W-1:0];
						free_n         = free_q + CNT_W'(1);
						state_n        = ST_ZERO;
					end
				end
			end
			ST_ZERO: begin
				mem_we = 1'b1;
				finish = 1'b1;
			end
			ST_HOLD: begin
				finish   = 1'b1;
				fin_last = 1'b1;
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase

		// Close the digit: emit on the final one, hold while the output is full
		res_present = !missed_n;
		res_ovf     = ovf_n;
		used_wide   = (CNT_W + OUT_W)'(free_n - CNT_W'(1));
		if (finish) begin
			if (!fin_last) begin
				state_n = ST_IDLE;
			end else if (out_free) begin
				emit     = 1'b1;
				cur_n    = ROOT_V;
				lost_n   = 1'b0;
				missed_n = 1'b0;
				ovf_n    = 1'b0;
				state_n  = ST_IDLE;
			end else begin
				state_n = ST_HOLD;
			end
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			cur_q       <= ROOT_V;
			free_q      <= FREE_RST;
			lost_q      <= 1'b0;
			missed_q    <= 1'b0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_n;
			cur_q    <= cur_n;
			free_q   <= free_n;
			lost_q   <= lost_n;
			missed_q <= missed_n;
			ovf_q    <= ovf_n;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Hold the accepted digit and the result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			dig_q  <= digit[DIG_W-1:0];
			last_q <= last_digit;
		end
		if (emit) begin
			out_present_q <= res_present;
			out_ovf_q     <= res_ovf;
			out_used_q    <= used_wide[OUT_W-1:0];
		end
	end

	assign out_valid       = out_valid_q;
	assign already_present = out_present_q;
	assign pool_overflow   = out_ovf_q;
	assign nodes_used      = out_used_q;

`ifndef ASSERT_OFF
	a_free_range: assert property (@(posedge clk) disable iff (!arst_n)
		(free_q >= FREE_RST) && (free_q <= FULL_V))
		else $error("free node counter out of range");

	a_write_empty_link: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOOK && mem_we) |-> (rd_link == '0))
		else $error("link written over an existing child");

	a_alloc_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOOK && mem_we) |=> (state_q == ST_ZERO && mem_we))
		else $error("allocated node row not zeroed");

	a_lost_missed: assert property (@(posedge clk) disable iff (!arst_n)
		lost_q |-> missed_q)
		else $error("lost walk without miss flag");
`endif

endmodule

`default_nettype wire
